### rtl/cffr_pkg.sv
// Shared types, constants and a helper function for the case-folding find and replace block.
package cffr_pkg;

   // Data and window sizing.
   localparam int BYTE_W      = 8;
   localparam int WIN_DEPTH   = 16;
   localparam int CNT_W       = 5;
   localparam int PATTERN_MAX = 16;
   localparam int REPL_MAX    = 16;

   // Job queue between the front and back parts.
   localparam int QUEUE_DEPTH = 4;
   localparam int QPTR_W      = 2;
   localparam int QCNT_W      = 3;

   // Configuration port.
   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = 64;

   // Length limits after clamping.
   localparam logic [CNT_W-1:0] PLEN_CAP =
      CNT_W'((PATTERN_MAX < WIN_DEPTH) ? PATTERN_MAX : WIN_DEPTH);
   localparam logic [CNT_W-1:0] RLEN_CAP =
      CNT_W'((REPL_MAX < WIN_DEPTH) ? REPL_MAX : WIN_DEPTH);

   // ASCII letters and the distance between the two cases.
   localparam logic [BYTE_W-1:0] CHAR_UPPER_A = 8'h41;
   localparam logic [BYTE_W-1:0] CHAR_UPPER_Z = 8'h5A;
   localparam logic [BYTE_W-1:0] CHAR_LOWER_A = 8'h61;
   localparam logic [BYTE_W-1:0] CHAR_LOWER_Z = 8'h7A;
   localparam logic [BYTE_W-1:0] CASE_OFFSET  = 8'd32;

   // Register indexes.
   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_PATTERN_LEN = 3'd0,
      CSR_PATTERN_LO  = 3'd1,
      CSR_PATTERN_HI  = 3'd2,
      CSR_REPL_LEN    = 3'd3,
      CSR_REPL_LO     = 3'd4,
      CSR_REPL_HI     = 3'd5
   } csr_index_type;

   // Effective configuration as seen by the datapath.
   typedef struct packed {
      logic [CNT_W-1:0]                  plen;
      logic [CNT_W-1:0]                  rlen;
      logic [WIN_DEPTH-1:0][BYTE_W-1:0]  pattern;
      logic [WIN_DEPTH-1:0][BYTE_W-1:0]  repl;
   } cffr_cfg_type;

   // One queued job: all results caused by one input transaction.
   typedef struct packed {
      logic [WIN_DEPTH-1:0][BYTE_W-1:0]  data;
      logic [CNT_W-1:0]                  n_bytes;
      logic                              text_end;
   } cffr_job_type;

   // Case-insensitive byte compare for ASCII letters.
   function automatic logic fold_eq(input logic [BYTE_W-1:0] t,
                                    input logic [BYTE_W-1:0] p);
      logic result;
      result = (t == p);
      if (t >= CHAR_UPPER_A && t <= CHAR_UPPER_Z && p == t + CASE_OFFSET) begin
         result = 1'b1;
      end
      if (t >= CHAR_LOWER_A && t <= CHAR_LOWER_Z && p + CASE_OFFSET == t) begin
         result = 1'b1;
      end
      return result;
   endfunction

endpackage

### rtl/cffr_front.sv
// Front part: accepts text bytes, keeps the match window and classifies each byte into a job.
module cffr_front
   import cffr_pkg::*;
(
   input  logic                clock,
   input  logic                reset,
   input  cffr_cfg_type        cfg,
   input  logic                win_clear,
   input  logic                req_valid,
   input  logic [BYTE_W-1:0]   req_text_byte,
   input  logic                req_text_last,
   output logic                req_stall,
   input  logic                q_full,
   output logic                push,
   output cffr_job_type        push_job
);

   logic [WIN_DEPTH-1:0][BYTE_W-1:0] win_ff, win_in;
   logic [CNT_W-1:0]                 fill_ff, fill_in;
   logic [WIN_DEPTH-1:0][BYTE_W-1:0] cand;
   logic [WIN_DEPTH-1:0][BYTE_W-1:0] shifted;
   logic [CNT_W-1:0]                 fill_base;
   logic [CNT_W-1:0]                 fill_new;
   logic                             full;
   logic                             hit;
   logic                             accept;

   assign req_stall = q_full;
   assign accept    = req_valid && !q_full;

   // Place the new byte behind the bytes already in the window.
   always_comb begin
      fill_base = (fill_ff >= cfg.plen) ? '0 : fill_ff;
      fill_new  = fill_base + CNT_W'(1);
      full      = (fill_new >= cfg.plen);
      for (int i = 0; i < WIN_DEPTH; i++) begin
         cand[i] = (fill_base == CNT_W'(i)) ? req_text_byte : win_ff[i];
      end
      for (int i = 0; i < WIN_DEPTH - 1; i++) begin
         shifted[i] = cand[i+1];
      end
      shifted[WIN_DEPTH-1] = cand[WIN_DEPTH-1];
   end

   // Compare every window position in use with the pattern in parallel.
   always_comb begin
      hit = full;
      for (int i = 0; i < WIN_DEPTH; i++) begin
         if (CNT_W'(i) < cfg.plen && !fold_eq(cand[i], cfg.pattern[i])) begin
            hit = 1'b0;
         end
      end
   end

   // Build the job and the next window state.
   always_comb begin
      push_job.text_end = req_text_last;
      if (hit) begin
         push_job.data    = cfg.repl;
         push_job.n_bytes = cfg.rlen;
         win_in           = cand;
         fill_in          = '0;
      end else if (full) begin
         push_job.data    = cand;
         push_job.n_bytes = req_text_last ? cfg.plen : CNT_W'(1);
         win_in           = shifted;
         fill_in          = fill_new - CNT_W'(1);
      end else begin
         push_job.data    = cand;
         push_job.n_bytes = req_text_last ? fill_new : '0;
         win_in           = cand;
         fill_in          = fill_new;
      end
      if (req_text_last) begin
         fill_in = '0;
      end
      push = accept && (push_job.n_bytes != '0 || req_text_last);
   end

   // Window bytes carry no reset; the fill count does.
   always_ff @(posedge clock) begin
      if (accept) begin
         win_ff <= win_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         fill_ff <= '0;
      end else if (win_clear) begin
         fill_ff <= '0;
      end else if (accept) begin
         fill_ff <= fill_in;
      end
   end

`ifndef SYNTHESIS
   // The window never holds a full pattern between transactions.
   assert property (@(posedge clock) disable iff (reset) fill_ff < cfg.plen)
      else $error("window fill reached the pattern length");
`endif

endmodule

### rtl/cffr_queue.sv
// Short job queue that decouples the front part from the back part.
module cffr_queue
   import cffr_pkg::*;
(
   input  logic          clock,
   input  logic          reset,
   input  logic          push,
   input  cffr_job_type  push_job,
   input  logic          pop,
   output cffr_job_type  head,
   output logic          empty,
   output logic          full
);

   cffr_job_type              entry_ff [QUEUE_DEPTH];
   logic [QPTR_W-1:0]         wr_ptr_ff, wr_ptr_in;
   logic [QPTR_W-1:0]         rd_ptr_ff, rd_ptr_in;
   logic [QCNT_W-1:0]         count_ff, count_in;

   assign empty = (count_ff == '0);
   assign full  = (count_ff == QCNT_W'(QUEUE_DEPTH));
   assign head  = entry_ff[rd_ptr_ff];

   // Pointer and occupancy updates.
   always_comb begin
      wr_ptr_in = push ? wr_ptr_ff + QPTR_W'(1) : wr_ptr_ff;
      rd_ptr_in = pop ? rd_ptr_ff + QPTR_W'(1) : rd_ptr_ff;
      count_in  = count_ff + QCNT_W'(push) - QCNT_W'(pop);
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_job;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

`ifndef SYNTHESIS
   // The front part must hold off while the queue is full.
   assert property (@(posedge clock) disable iff (reset) !(push && full))
      else $error("job pushed into a full queue");
   // The back part must not take a job that is not there.
   assert property (@(posedge clock) disable iff (reset) !(pop && empty))
      else $error("job popped from an empty queue");
   // Occupancy never exceeds the queue depth.
   assert property (@(posedge clock) disable iff (reset)
                    count_ff <= QCNT_W'(QUEUE_DEPTH))
      else $error("queue occupancy out of range");
`endif

endmodule

### rtl/cffr_back.sv
// Back part: expands queued jobs into result transactions through an output register.
module cffr_back
   import cffr_pkg::*;
(
   input  logic                clock,
   input  logic                reset,
   input  cffr_job_type        head,
   input  logic                empty,
   output logic                pop,
   output logic                rsp_valid,
   input  logic                rsp_stall,
   output logic [BYTE_W-1:0]   rsp_out_byte,
   output logic                rsp_run_last,
   output logic                rsp_text_end
);

   logic [CNT_W-1:0]   pos_ff, pos_in;
   logic               rsp_valid_ff, rsp_valid_in;
   logic [BYTE_W-1:0]  byte_ff, byte_in;
   logic               run_last_ff, run_last_in;
   logic               text_end_ff, text_end_in;
   logic [CNT_W-1:0]   total;
   logic               load;
   logic               issue;
   logic               final_item;

   assign rsp_valid    = rsp_valid_ff;
   assign rsp_out_byte = byte_ff;
   assign rsp_run_last = run_last_ff;
   assign rsp_text_end = text_end_ff;

   // The output register takes a new result when it is empty or being drained.
   always_comb begin
      load       = !rsp_valid_ff || !rsp_stall;
      issue      = load && !empty;
      total      = head.n_bytes + CNT_W'(head.text_end);
      final_item = (pos_ff + CNT_W'(1) == total);
      pop        = issue && final_item;
      pos_in     = pop ? '0 : pos_ff + CNT_W'(1);
   end

   // Choose the text byte or the end marker for the current position.
   always_comb begin
      run_last_in = final_item;
      if (pos_ff < head.n_bytes) begin
         byte_in     = head.data[pos_ff[3:0]];
         text_end_in = 1'b0;
      end else begin
         byte_in     = '0;
         text_end_in = 1'b1;
      end
      rsp_valid_in = load ? !empty : rsp_valid_ff;
   end

   always_ff @(posedge clock) begin
      if (issue) begin
         byte_ff     <= byte_in;
         run_last_ff <= run_last_in;
         text_end_ff <= text_end_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
         pos_ff       <= '0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
         if (issue) begin
            pos_ff <= pos_in;
         end
      end
   end

`ifndef SYNTHESIS
   // The position within a job stays inside that job's result count.
   assert property (@(posedge clock) disable iff (reset) !empty |-> pos_ff < total)
      else $error("result position beyond the current job");
   // An end marker always closes the results of its transaction.
   assert property (@(posedge clock) disable iff (reset)
                    rsp_valid_ff && text_end_ff |-> run_last_ff)
      else $error("end marker without run_last");
`endif

endmodule

### rtl/case_fold_find_replace.sv
// Top level of the case-insensitive streaming find and replace block.
//
// Text bytes enter on the req_ channel at up to one transaction per cycle and are matched
// against the configured pattern (1 to 16 characters, ASCII letters compared without regard
// to case); results leave on the rsp_ channel through an output register, one per cycle
// while rsp_stall is low. An unmatched byte gives one result, a match gives repl_len results
// (possibly none), and the byte marked last also gives the remaining window bytes and an end
// marker. The front part classifies one byte per cycle with a parallel window compare; a
// four-job queue lets it run ahead while the back part expands replacements, so input stalls
// only when that queue fills, which takes results coming out more slowly than text goes in:
// long replacements, end-of-text flushes or a stalled rsp_ channel. Results are built from
// jobs held in the queue. Configuration writes are always taken (csr_ready is high)
// and must be made while the block is idle; writing pattern_len empties the window.
module case_fold_find_replace
   import cffr_pkg::*;
(
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_stall,
   input  logic [BYTE_W-1:0]      req_text_byte,
   input  logic                   req_text_last,
   output logic                   rsp_valid,
   input  logic                   rsp_stall,
   output logic [BYTE_W-1:0]      rsp_out_byte,
   output logic                   rsp_run_last,
   output logic                   rsp_text_end,
   input  logic                   csr_valid,
   output logic                   csr_ready,
   input  logic [CSR_IDX_W-1:0]   csr_index,
   input  logic [CSR_DATA_W-1:0]  csr_wdata
);

   logic [CNT_W-1:0]       pattern_len_ff;
   logic [CSR_DATA_W-1:0]  pattern_lo_ff;
   logic [CSR_DATA_W-1:0]  pattern_hi_ff;
   logic [CNT_W-1:0]       repl_len_ff;
   logic [CSR_DATA_W-1:0]  repl_lo_ff;
   logic [CSR_DATA_W-1:0]  repl_hi_ff;
   logic                   csr_write;
   logic                   win_clear;
   cffr_cfg_type           cfg;
   logic                   push;
   cffr_job_type           push_job;
   logic                   pop;
   cffr_job_type           head;
   logic                   q_empty;
   logic                   q_full;

   assign csr_ready = 1'b1;
   assign csr_write = csr_valid && csr_ready;
   assign win_clear = csr_write && (csr_index == CSR_PATTERN_LEN);

   // Configuration registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         pattern_len_ff <= CNT_W'(1);
         pattern_lo_ff  <= '0;
         pattern_hi_ff  <= '0;
         repl_len_ff    <= '0;
         repl_lo_ff     <= '0;
         repl_hi_ff     <= '0;
      end else if (csr_write) begin
         unique case (csr_index)
            CSR_PATTERN_LEN: pattern_len_ff <= csr_wdata[CNT_W-1:0];
            CSR_PATTERN_LO:  pattern_lo_ff  <= csr_wdata;
            CSR_PATTERN_HI:  pattern_hi_ff  <= csr_wdata;
            CSR_REPL_LEN:    repl_len_ff    <= csr_wdata[CNT_W-1:0];
            CSR_REPL_LO:     repl_lo_ff     <= csr_wdata;
            CSR_REPL_HI:     repl_hi_ff     <= csr_wdata;
            default: begin
            end
         endcase
      end
   end

   // Clamp the lengths and gather the effective configuration.
   always_comb begin
      priority if (pattern_len_ff == '0) begin
         cfg.plen = CNT_W'(1);
      end else if (pattern_len_ff > PLEN_CAP) begin
         cfg.plen = PLEN_CAP;
      end else begin
         cfg.plen = pattern_len_ff;
      end
      cfg.rlen    = (repl_len_ff > RLEN_CAP) ? RLEN_CAP : repl_len_ff;
      cfg.pattern = {pattern_hi_ff, pattern_lo_ff};
      cfg.repl    = {repl_hi_ff, repl_lo_ff};
   end

   cffr_front u_front (
      .clock         (clock),
      .reset         (reset),
      .cfg           (cfg),
      .win_clear     (win_clear),
      .req_valid     (req_valid),
      .req_text_byte (req_text_byte),
      .req_text_last (req_text_last),
      .req_stall     (req_stall),
      .q_full        (q_full),
      .push          (push),
      .push_job      (push_job)
   );

   cffr_queue u_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (push),
      .push_job (push_job),
      .pop      (pop),
      .head     (head),
      .empty    (q_empty),
      .full     (q_full)
   );

   cffr_back u_back (
      .clock        (clock),
      .reset        (reset),
      .head         (head),
      .empty        (q_empty),
      .pop          (pop),
      .rsp_valid    (rsp_valid),
      .rsp_stall    (rsp_stall),
      .rsp_out_byte (rsp_out_byte),
      .rsp_run_last (rsp_run_last),
      .rsp_text_end (rsp_text_end)
   );

endmodule
